@@ sv/phs_pkg.sv @@
// Shared types, constants and helper functions for the six-stage allpass phaser.
// No dependencies; imported by six_stage_allpass_phaser and phs_div.
package phs_pkg;

    // Register reset values
    localparam logic [15:0] MIN_CORNER_RST    = 16'd1201;
    localparam logic [15:0] MAX_CORNER_RST    = 16'd4369;
    localparam logic [30:0] PHASE_STEP_RST    = 31'd44739;
    localparam logic [14:0] FEEDBACK_GAIN_RST = 15'd22938;
    localparam logic [15:0] MIX_DEPTH_RST     = 16'd32768;

    // Register indexes on the configuration port
    localparam int unsigned CFG_ADDR_W = 3;
    localparam int unsigned CFG_DATA_W = 31;
    localparam logic [CFG_ADDR_W-1:0] REG_MIN_CORNER    = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_MAX_CORNER    = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_PHASE_STEP    = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_FEEDBACK_GAIN = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_MIX_DEPTH     = 3'd4;

    // Default structural parameters
    localparam int unsigned STAGE_COUNT_DEF = 6;
    localparam int unsigned SAMPLE_BITS_DEF = 16;

    // Sine polynomial coefficients, Q1.15
    localparam logic [15:0] SIN_A = 16'd51472;
    localparam logic [15:0] SIN_B = 16'd21024;
    localparam logic [15:0] SIN_C = 16'd2320;
    localparam logic [16:0] HALF_SCALE = 17'd32768;

    // Coefficient divider widths
    localparam int unsigned DIV_NUM_W = 32;
    localparam int unsigned DIV_DEN_W = 18;
    localparam int unsigned COEF_W    = 15;

    // Chain word, Q1.23
    localparam int unsigned CHAIN_W = 24;
    localparam int unsigned WIDE_W  = 27;

    typedef logic signed [CHAIN_W-1:0] chain_t;
    typedef logic signed [WIDE_W-1:0]  wide_t;

    // Saturate a wide intermediate to Q1.23
    function automatic chain_t sat_q23(input wide_t v);
        wide_t hi;
        wide_t lo;
        hi = wide_t'(24'sh7FFFFF);
        lo = -wide_t'(27'sd8388608);
        if (v > hi)
            sat_q23 = chain_t'(hi);
        else if (v < lo)
            sat_q23 = chain_t'(lo);
        else
            sat_q23 = chain_t'(v);
    endfunction

endpackage

@@ sv/six_stage_allpass_phaser.sv @@
// Top level of the allpass phaser: sequencer, shared multiplier, state and ports.
// Depends on phs_pkg and phs_div.
//
// Channel   Direction  Handshake          Payload
// s_axis    in         s_tvalid/s_tready  s_tdata: sample_in
// m_axis    out        m_tvalid/m_tready  m_tdata: sample_out
// cfg       in         cfg_we             cfg_addr, cfg_wdata
//
// One sample is worked at a time, through the bit-serial coefficient divider
// and the one shared multiplier.
// s_tready is high only while the sequencer is idle; a finished result waits in
// the output register, and the sequencer holds in its last step if that is full.
// rst_n clears the LFO phase, all stage states and feedback, and reloads registers.
module six_stage_allpass_phaser
    import phs_pkg::*;
#(
    parameter int unsigned STAGE_COUNT = STAGE_COUNT_DEF,
    parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF,
    localparam int unsigned TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [TDATA_W-1:0]    s_tdata,   // [SAMPLE_BITS-1:0] sample_in
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [TDATA_W-1:0]    m_tdata,   // [SAMPLE_BITS-1:0] sample_out
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int unsigned SHIFT_IN = 24 - SAMPLE_BITS;
    localparam int unsigned IDX_W = (STAGE_COUNT > 1) ? $clog2(STAGE_COUNT) : 1;
    localparam int unsigned ST_W = 4;

    localparam logic [ST_W-1:0] S_IDLE = 4'd0;
    localparam logic [ST_W-1:0] S_T2   = 4'd1;
    localparam logic [ST_W-1:0] S_C    = 4'd2;
    localparam logic [ST_W-1:0] S_IN1  = 4'd3;
    localparam logic [ST_W-1:0] S_IN2  = 4'd4;
    localparam logic [ST_W-1:0] S_U    = 4'd5;
    localparam logic [ST_W-1:0] S_DMAX = 4'd6;
    localparam logic [ST_W-1:0] S_DSUM = 4'd7;
    localparam logic [ST_W-1:0] S_X    = 4'd8;
    localparam logic [ST_W-1:0] S_DIVW = 4'd9;
    localparam logic [ST_W-1:0] S_ST0  = 4'd10;
    localparam logic [ST_W-1:0] S_ST1  = 4'd11;
    localparam logic [ST_W-1:0] S_ST2  = 4'd12;
    localparam logic [ST_W-1:0] S_MIX  = 4'd13;
    localparam logic [ST_W-1:0] S_OUT  = 4'd14;

    // Configuration registers
    logic [15:0] min_corner_reg;
    logic [15:0] max_corner_reg;
    logic [30:0] phase_step_reg;
    logic [14:0] feedback_gain_reg;
    logic [15:0] mix_depth_reg;

    // Persistent state
    logic [31:0] lfo_phase_reg;
    chain_t      stage_mem_reg [STAGE_COUNT];
    chain_t      last_chain_reg;

    // Sequencer and working registers
    logic [ST_W-1:0]        state_reg;
    logic [ST_W-1:0]        state_next;
    logic [IDX_W-1:0]       idx_reg;
    logic [SAMPLE_BITS-1:0] sample_reg;
    logic [15:0]            t_reg;
    logic [1:0]             quad_reg;
    logic [15:0]            t2_reg;
    logic [16:0]            u_reg;
    logic [31:0]            acc_reg;
    logic [COEF_W-1:0]      a_reg;
    chain_t                 x_reg;
    chain_t                 y_reg;
    logic                   out_valid_reg;
    logic [SAMPLE_BITS-1:0] out_data_reg;

    // Shared multiplier
    logic                 mul_en;
    logic signed [24:0]   mul_a;
    logic signed [17:0]   mul_b;
    logic signed [42:0]   prod_reg;

    // Divider link
    logic                 div_start;
    logic                 div_busy;
    logic [DIV_NUM_W-1:0] div_num;
    logic [DIV_DEN_W-1:0] div_den;
    logic [COEF_W-1:0]    div_quot;

    // Datapath terms
    logic [1:0]   quad_in;
    logic [15:0]  t_in;
    logic [15:0]  pq15;
    logic [15:0]  inner1;
    logic [15:0]  inner2;
    logic [16:0]  s_cap;
    logic [16:0]  u_now;
    logic [32:0]  d_sum;
    logic [15:0]  d_val;
    logic [16:0]  den17;
    chain_t       smp_q23;
    chain_t       mem_rd;
    wide_t        fb_sum;
    wide_t        st_y;
    wide_t        st_m;
    wide_t        wet;
    wide_t        wet_sh;
    logic         accept;
    logic         out_free;
    logic [SAMPLE_BITS-1:0] wet_sat;

    localparam wide_t SMAX = wide_t'((1 << (SAMPLE_BITS - 1)) - 1);
    localparam wide_t SMIN = -wide_t'(1 << (SAMPLE_BITS - 1));

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign out_free = !out_valid_reg || m_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = TDATA_W'(out_data_reg);

    // Fold the phase into the first quadrant
    assign quad_in = lfo_phase_reg[31:30];
    assign t_in    = quad_in[0] ? (16'd32768 - {1'b0, lfo_phase_reg[29:15]})
                                : {1'b0, lfo_phase_reg[29:15]};

    // Sine, sweep and coefficient terms
    always_comb
    begin
        pq15   = prod_reg[30:15];
        inner1 = SIN_B - pq15;
        inner2 = SIN_A - pq15;
        s_cap  = (prod_reg[31:15] > HALF_SCALE) ? HALF_SCALE : prod_reg[31:15];
        u_now  = quad_reg[1] ? (HALF_SCALE - s_cap) : (HALF_SCALE + s_cap);
        d_sum  = {1'b0, acc_reg} + {1'b0, prod_reg[31:0]};
        d_val  = d_sum[31:16];
        den17  = 17'd65536 + {1'b0, d_val};
        div_num = ({15'd0, 17'd65536 - {1'b0, d_val}} << 15) + {15'd0, den17};
        div_den = {den17, 1'b0};
    end

    // Chain arithmetic
    always_comb
    begin
        smp_q23 = chain_t'($signed(sample_reg)) <<< SHIFT_IN;
        mem_rd  = stage_mem_reg[idx_reg];
        fb_sum  = wide_t'(smp_q23) + wide_t'($signed(prod_reg[38:15]));
        st_y    = wide_t'(mem_rd) - wide_t'($signed(prod_reg[38:14]));
        st_m    = wide_t'($signed(prod_reg[38:14])) + wide_t'(x_reg);
        wet     = wide_t'(smp_q23) + wide_t'($signed(prod_reg[40:15]));
        wet_sh  = wet >>> SHIFT_IN;
        if (wet_sh > SMAX)
            wet_sat = SAMPLE_BITS'(SMAX);
        else if (wet_sh < SMIN)
            wet_sat = SAMPLE_BITS'(SMIN);
        else
            wet_sat = SAMPLE_BITS'(wet_sh);
    end

    // Select multiplier operands and next step
    always_comb
    begin
        state_next = state_reg;
        mul_en     = 1'b0;
        mul_a      = '0;
        mul_b      = '0;
        div_start  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                    state_next = S_T2;
            end
            S_T2:
            begin
                mul_en = 1'b1;
                mul_a  = 25'(t_reg);
                mul_b  = 18'(t_reg);
                state_next = S_C;
            end
            S_C:
            begin
                mul_en = 1'b1;
                mul_a  = 25'(SIN_C);
                mul_b  = 18'(pq15);
                state_next = S_IN1;
            end
            S_IN1:
            begin
                mul_en = 1'b1;
                mul_a  = 25'(t2_reg);
                mul_b  = 18'(inner1);
                state_next = S_IN2;
            end
            S_IN2:
            begin
                mul_en = 1'b1;
                mul_a  = 25'(t_reg);
                mul_b  = 18'(inner2);
                state_next = S_U;
            end
            S_U:
            begin
                mul_en = 1'b1;
                mul_a  = 25'(min_corner_reg);
                mul_b  = 18'(18'd65536 - 18'(u_now));
                state_next = S_DMAX;
            end
            S_DMAX:
            begin
                mul_en = 1'b1;
                mul_a  = 25'(max_corner_reg);
                mul_b  = 18'(u_reg);
                state_next = S_DSUM;
            end
            S_DSUM:
            begin
                mul_en = 1'b1;
                mul_a  = 25'(last_chain_reg);
                mul_b  = 18'(feedback_gain_reg);
                div_start = 1'b1;
                state_next = S_X;
            end
            S_X:
            begin
                state_next = S_DIVW;
            end
            S_DIVW:
            begin
                if (!div_busy)
                    state_next = S_ST0;
            end
            S_ST0:
            begin
                mul_en = 1'b1;
                mul_a  = 25'(x_reg);
                mul_b  = 18'(a_reg);
                state_next = S_ST1;
            end
            S_ST1:
            begin
                mul_en = 1'b1;
                mul_a  = 25'(sat_q23(st_y));
                mul_b  = 18'(a_reg);
                state_next = S_ST2;
            end
            S_ST2:
            begin
                state_next = (idx_reg == '0) ? S_MIX : S_ST0;
            end
            S_MIX:
            begin
                mul_en = 1'b1;
                mul_a  = 25'(x_reg);
                mul_b  = 18'(mix_depth_reg);
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Register the product of the shared multiplier
    always_ff @(posedge clk)
    begin
        if (mul_en)
            prod_reg <= mul_a * mul_b;
    end

    // Sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // Configuration writes; unknown indexes drop
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_corner_reg    <= MIN_CORNER_RST;
            max_corner_reg    <= MAX_CORNER_RST;
            phase_step_reg    <= PHASE_STEP_RST;
            feedback_gain_reg <= FEEDBACK_GAIN_RST;
            mix_depth_reg     <= MIX_DEPTH_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_MIN_CORNER:    min_corner_reg    <= cfg_wdata[15:0];
                REG_MAX_CORNER:    max_corner_reg    <= cfg_wdata[15:0];
                REG_PHASE_STEP:    phase_step_reg    <= cfg_wdata[30:0];
                REG_FEEDBACK_GAIN: feedback_gain_reg <= cfg_wdata[14:0];
                REG_MIX_DEPTH:     mix_depth_reg     <= cfg_wdata[15:0];
                default:           ;
            endcase
        end
    end

    // Persistent state: phase, stage memories, feedback, stage index, output
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lfo_phase_reg  <= '0;
            last_chain_reg <= '0;
            idx_reg        <= '0;
            out_valid_reg  <= 1'b0;
            for (int i = 0; i < STAGE_COUNT; i++)
                stage_mem_reg[i] <= '0;
        end
        else
        begin
            if (state_reg == S_OUT && out_free)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        lfo_phase_reg <= lfo_phase_reg + {1'b0, phase_step_reg};
                        idx_reg       <= IDX_W'(STAGE_COUNT - 1);
                    end
                end
                S_ST2:
                begin
                    stage_mem_reg[idx_reg] <= sat_q23(st_m);
                    if (idx_reg != '0)
                        idx_reg <= idx_reg - 1'b1;
                end
                S_MIX:
                begin
                    last_chain_reg <= x_reg;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Working payload registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    sample_reg <= s_tdata[SAMPLE_BITS-1:0];
                    t_reg      <= t_in;
                    quad_reg   <= quad_in;
                end
            end
            S_C:    t2_reg  <= pq15;
            S_U:    u_reg   <= u_now;
            S_DMAX: acc_reg <= prod_reg[31:0];
            S_X:    x_reg   <= sat_q23(fb_sum);
            S_DIVW: a_reg   <= div_quot;
            S_ST1:  y_reg   <= sat_q23(st_y);
            S_ST2:  x_reg   <= y_reg;
            S_OUT:
            begin
                if (out_free)
                    out_data_reg <= wet_sat;
            end
            default:
            begin
            end
        endcase
    end

    phs_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .busy  (div_busy),
        .quot  (div_quot)
    );

endmodule

@@ sv/phs_div.sv @@
// Radix-2 restoring divider for the allpass coefficient, one quotient bit per cycle.
// Depends on phs_pkg.
module phs_div
    import phs_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [DIV_NUM_W-1:0] num,
    input  logic [DIV_DEN_W-1:0] den,
    output logic                 busy,
    output logic [COEF_W-1:0]    quot
);

    localparam int unsigned CNT_W = $clog2(DIV_NUM_W + 1);

    logic [CNT_W-1:0]     cnt_reg;
    logic [DIV_DEN_W-1:0] rem_reg;
    logic [DIV_NUM_W-1:0] q_reg;
    logic [DIV_DEN_W-1:0] den_reg;
    logic [DIV_DEN_W:0]   trial;
    logic [DIV_DEN_W:0]   diff;
    logic                 qbit;

    // Shift in the next dividend bit and try the subtraction
    always_comb
    begin
        trial = {rem_reg, q_reg[DIV_NUM_W-1]};
        diff  = trial - {1'b0, den_reg};
        qbit  = (trial >= {1'b0, den_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (start)
        begin
            cnt_reg <= CNT_W'(DIV_NUM_W);
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            q_reg   <= num;
            den_reg <= den;
        end
        else if (cnt_reg != '0)
        begin
            rem_reg <= qbit ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
            q_reg   <= {q_reg[DIV_NUM_W-2:0], qbit};
        end
    end

    assign busy = (cnt_reg != '0);
    assign quot = q_reg[COEF_W-1:0];

endmodule

@@ sv/phs_checker.sv @@
// Port-level checks for the allpass phaser, attached by bind.
// Depends on six_stage_allpass_phaser ports only.
module phs_checker #(
    parameter int unsigned TDATA_W = 16
)
(
    input logic               clk,
    input logic               rst_n,
    input logic               s_tvalid,
    input logic               s_tready,
    input logic [TDATA_W-1:0] s_tdata,
    input logic               m_tvalid,
    input logic               m_tready,
    input logic [TDATA_W-1:0] m_tdata
);

    // A stalled result holds its value
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // After a request the block stays busy for the work
    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready ##1 !s_tready)
        else $error("ready returned too early");

    // A new result never appears while the input side is open
    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result without work");

endmodule

bind six_stage_allpass_phaser phs_checker #(.TDATA_W(TDATA_W)) u_phs_checker (.*);
